// ----- rtl/blmsf_pkg.sv -----
// Shared types and constants for the bicolor LED matrix scan framebuffer.
// No dependencies; imported by the top level, the shift-out unit and the checker.
package blmsf_pkg;

  // Default panel geometry
  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 32;

  // The panel is driven as two halves of SCAN_ROWS rows each
  localparam int SCAN_ROWS = 16;

  // Widths used for coordinate range checks (cover the widest panel)
  localparam int X_EXT_W    = 9;
  localparam int ROW_CALC_W = 8;

  // Command codes on in_func
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Bits of in_color
  localparam int COLOR_RED_BIT   = 0;
  localparam int COLOR_GREEN_BIT = 1;

  // Reset value of the row offset register
  localparam logic [3:0] ROW_OFFSET_RESET = 4'd1;

  // Control from the sequencer to the shift-out unit
  typedef struct packed {
    logic load_top;  // capture the top half row from the RAM read data
    logic load_bot;  // capture the bottom half row from the RAM read data
    logic row_live;  // row is on the panel and written since the last clear
    logic shift;     // advance one column
  } shift_ctrl_t;

endpackage

// ----- rtl/bicolor_led_matrix_scan_framebuffer_top.sv -----
// Top level of the bicolor LED matrix scan framebuffer: sequencer and row valid bits.
// Depends on blmsf_pkg, blmsf_ram and blmsf_shifter.

// A command is taken when start is high and busy is low. A draw reads the row,
// then writes the modified row back; a clear does not raise busy. For a tick,
// two reads of the single RAM port fetch the top and bottom half rows, then one
// column leaves per cycle. Each shift result is on the out_ ports for exactly
// one cycle with out_valid high; the receiver must take it then. The last
// column of a tick carries out_latch and the row address. Clear is instant:
// per-row valid bits mark which RAM rows hold data, so there is no clearing
// pass after reset. cfg_ready is always high; write row_offset only while
// busy is low.
module bicolor_led_matrix_scan_framebuffer_top import blmsf_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [5:0] in_x,
  input  logic [4:0] in_y,
  input  logic [1:0] in_color,
  // shift results
  output logic       out_valid,
  output logic       out_red_top,
  output logic       out_red_bottom,
  output logic       out_green_top,
  output logic       out_green_bottom,
  output logic [3:0] out_row_address,
  output logic       out_latch,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_row_offset
);

  localparam int CW = $clog2(PANEL_WIDTH);
  localparam int RW = $clog2(PANEL_HEIGHT);
  localparam int DW = 2 * PANEL_WIDTH;
  localparam logic [CW-1:0] LAST_COL = CW'(PANEL_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_WR,
    ST_READ_TOP,
    ST_READ_BOT,
    ST_SHIFT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PANEL_HEIGHT-1:0] row_valid_r, row_valid_nxt;
  logic [3:0]              scan_row_r, scan_row_nxt;
  logic [3:0]              row_offset_r, row_offset_nxt;
  logic [CW-1:0]           col_r, col_nxt;
  logic [CW-1:0]           draw_col_r, draw_col_nxt;
  logic [RW-1:0]           draw_row_r, draw_row_nxt;
  logic [1:0]              color_r, color_nxt;

  logic                    ram_we;
  logic [RW-1:0]           ram_addr;
  logic [DW-1:0]           ram_wdata, ram_rdata;
  shift_ctrl_t             sh_ctrl;

  logic [X_EXT_W-1:0]      x_ext;
  logic [ROW_CALC_W-1:0]   y_ext, top_row, bot_row;
  logic                    draw_in_panel, top_live, bot_live;
  logic [PANEL_WIDTH-1:0]  red_mod, green_mod;

  // Coordinate checks
  assign x_ext         = X_EXT_W'(in_x);
  assign y_ext         = ROW_CALC_W'(in_y);
  assign draw_in_panel = (x_ext < X_EXT_W'(PANEL_WIDTH)) &&
                         (y_ext < ROW_CALC_W'(PANEL_HEIGHT));

  // Scan row pair; rows off the panel or cleared read dark
  assign top_row  = ROW_CALC_W'(scan_row_r);
  assign bot_row  = top_row + ROW_CALC_W'(SCAN_ROWS);
  assign top_live = (top_row < ROW_CALC_W'(PANEL_HEIGHT)) && row_valid_r[top_row[RW-1:0]];
  assign bot_live = (bot_row < ROW_CALC_W'(PANEL_HEIGHT)) && row_valid_r[bot_row[RW-1:0]];

  // Read-modify-write of one row for a draw
  always_comb begin
    red_mod   = row_valid_r[draw_row_r] ? ram_rdata[PANEL_WIDTH-1:0] : '0;
    green_mod = row_valid_r[draw_row_r] ? ram_rdata[DW-1:PANEL_WIDTH] : '0;
    red_mod[draw_col_r]   = color_r[COLOR_RED_BIT];
    green_mod[draw_col_r] = color_r[COLOR_GREEN_BIT];
  end
  assign ram_wdata = {green_mod, red_mod};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    row_valid_nxt  = row_valid_r;
    scan_row_nxt   = scan_row_r;
    row_offset_nxt = row_offset_r;
    col_nxt        = col_r;
    draw_col_nxt   = draw_col_r;
    draw_row_nxt   = draw_row_r;
    color_nxt      = color_r;
    ram_we         = 1'b0;
    ram_addr       = top_row[RW-1:0];
    sh_ctrl        = '0;

    if (cfg_valid) begin
      row_offset_nxt = cfg_row_offset;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            FUNC_DRAW: begin
              if (draw_in_panel) begin
                ram_addr     = y_ext[RW-1:0];
                draw_col_nxt = x_ext[CW-1:0];
                draw_row_nxt = y_ext[RW-1:0];
                color_nxt    = in_color;
                state_nxt    = ST_DRAW_WR;
              end
            end
            FUNC_CLEAR: begin
              row_valid_nxt = '0;
            end
            FUNC_TICK: begin
              ram_addr  = top_row[RW-1:0];
              state_nxt = ST_READ_TOP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW_WR: begin
        ram_we                    = 1'b1;
        ram_addr                  = draw_row_r;
        row_valid_nxt[draw_row_r] = 1'b1;
        state_nxt                 = ST_IDLE;
      end
      ST_READ_TOP: begin
        sh_ctrl.load_top = 1'b1;
        sh_ctrl.row_live = top_live;
        ram_addr         = bot_row[RW-1:0];
        state_nxt        = ST_READ_BOT;
      end
      ST_READ_BOT: begin
        sh_ctrl.load_bot = 1'b1;
        sh_ctrl.row_live = bot_live;
        col_nxt          = '0;
        state_nxt        = ST_SHIFT;
      end
      ST_SHIFT: begin
        sh_ctrl.shift = 1'b1;
        col_nxt       = col_r + 1'b1;
        if (col_r == LAST_COL) begin
          scan_row_nxt = scan_row_r + 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_valid_r  <= '0;
      scan_row_r   <= '0;
      row_offset_r <= ROW_OFFSET_RESET;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      scan_row_r   <= scan_row_nxt;
      row_offset_r <= row_offset_nxt;
    end
    col_r      <= col_nxt;
    draw_col_r <= draw_col_nxt;
    draw_row_r <= draw_row_nxt;
    color_r    <= color_nxt;
  end

  // Both planes share one RAM word per row: green above red
  blmsf_ram #(
    .WIDTH (DW),
    .DEPTH (PANEL_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  blmsf_shifter #(
    .WIDTH (PANEL_WIDTH)
  ) u_shifter (
    .clk          (clk),
    .ctrl         (sh_ctrl),
    .rdata        (ram_rdata),
    .red_top      (out_red_top),
    .red_bottom   (out_red_bottom),
    .green_top    (out_green_top),
    .green_bottom (out_green_bottom)
  );

  // Port side
  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = (state_r == ST_SHIFT);
  assign out_latch       = out_valid && (col_r == LAST_COL);
  assign out_row_address = out_latch ? (scan_row_r + row_offset_r) : '0;

endmodule

// ----- rtl/blmsf_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module blmsf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write on the shared port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/blmsf_shifter.sv -----
// Shift-out unit: holds one scan row pair as active-low bits and shifts them out.
// Depends on blmsf_pkg for the control struct.
module blmsf_shifter import blmsf_pkg::*; #(
  parameter int WIDTH = PANEL_WIDTH_DEF
) (
  input  logic               clk,
  input  shift_ctrl_t        ctrl,
  input  logic [2*WIDTH-1:0] rdata,
  output logic               red_top,
  output logic               red_bottom,
  output logic               green_top,
  output logic               green_bottom
);

  logic [WIDTH-1:0] red_top_r, red_bot_r, green_top_r, green_bot_r;
  logic [WIDTH-1:0] red_load, green_load;

  // Dead rows read as all dark (ones); live rows are inverted to active low
  assign red_load   = ctrl.row_live ? ~rdata[WIDTH-1:0]       : '1;
  assign green_load = ctrl.row_live ? ~rdata[2*WIDTH-1:WIDTH] : '1;

  always_ff @(posedge clk) begin
    if (ctrl.load_top) begin
      red_top_r   <= red_load;
      green_top_r <= green_load;
    end else if (ctrl.shift) begin
      red_top_r   <= red_top_r >> 1;
      green_top_r <= green_top_r >> 1;
    end
    if (ctrl.load_bot) begin
      red_bot_r   <= red_load;
      green_bot_r <= green_load;
    end else if (ctrl.shift) begin
      red_bot_r   <= red_bot_r >> 1;
      green_bot_r <= green_bot_r >> 1;
    end
  end

  // Column 0 leaves first
  assign red_top      = red_top_r[0];
  assign red_bottom   = red_bot_r[0];
  assign green_top    = green_top_r[0];
  assign green_bottom = green_bot_r[0];

endmodule

// ----- rtl/blmsf_checker.sv -----
// Port-level checks for the bicolor LED matrix scan framebuffer, bound to the top.
// Depends on blmsf_pkg and bicolor_led_matrix_scan_framebuffer_top.
module blmsf_checker import blmsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_latch,
  input logic [3:0] out_row_address
);

  // Results only stream while a tick holds the block
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("shift result while not busy");

  // Latch marks a shift result
  a_latch_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_latch |-> out_valid)
    else $error("latch without shift result");

  // Row address is zero on every shift but the last
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_latch) |-> (out_row_address == 4'd0))
    else $error("row address on a non-latch shift");

  // The latch closes the row
  a_latch_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_latch |=> (!out_valid && !busy))
    else $error("transfer continues after latch");

  // A tick transfer always occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_TICK)) |=> busy)
    else $error("tick accepted without going busy");

endmodule

bind bicolor_led_matrix_scan_framebuffer_top blmsf_checker u_blmsf_checker (.*);
